FILE: hw/rtl/dnyd_pkg.sv
// Shared constants, widths and tables for the day number to year and day converter.
`timescale 1ns / 1ps
`default_nettype none
package dnyd_pkg;

    localparam int NUM_STAGES = 10;

    localparam int W_DAY  = 22;
    localparam int W_FRAC = 32;
    localparam int W_YEAR = 14;
    localparam int W_DOY  = 9;
    localparam int W_SEC  = 33;

    localparam int unsigned SEC_PER_DAY = 86400;
    localparam int W_SPD                = 17;
    localparam int W_SEC_PROD           = W_FRAC + W_SPD;
    localparam int SEC_FRAC_BITS        = 16;

    localparam int unsigned JD_OFFSET = 2400001;
    localparam int unsigned FVF_SHIFT = 68569;
    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned FVF_4000Y = 1461001;
    localparam int unsigned FVF_MONTH = 2447;
    localparam int unsigned FVF_CENT  = 49;
    localparam int unsigned L_OFFSET  = JD_OFFSET + FVF_SHIFT;

    // internal widths
    localparam int W_L0 = 23;
    localparam int W_N  = 8;
    localparam int W_L1 = 16;
    localparam int W_I  = 7;
    localparam int W_L2 = 10;
    localparam int W_J  = 4;
    localparam int W_M  = 4;

    // exact reciprocal division: k = bits(x) + ceil(log2(d)), m = ceil(2^k / d)
    localparam int W_X1 = 25;
    localparam int K1   = 43;
    localparam int W_R1 = 26;
    localparam longint unsigned R1 = ((64'd1 << K1) + DAYS_400Y - 1) / DAYS_400Y;

    localparam int W_X2 = 28;
    localparam int K2   = 49;
    localparam int W_R2 = 29;
    localparam longint unsigned R2 = ((64'd1 << K2) + FVF_4000Y - 1) / FVF_4000Y;

    localparam int W_X3 = 17;
    localparam int K3   = 29;
    localparam int W_R3 = 18;
    localparam longint unsigned R3 = ((64'd1 << K3) + FVF_MONTH - 1) / FVF_MONTH;

    function automatic logic [W_DOY-1:0] f_month_start(input logic [W_M-1:0] idx);
        logic [W_DOY-1:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(2447 * j / 80)
    function automatic logic [W_DOY-1:0] f_month_off(input logic [W_J-1:0] j);
        logic [W_DOY-1:0] v;
        unique case (j)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd458;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dnyd_date.sv
// Pipelined day number to Gregorian year and day-of-year datapath.
`timescale 1ns / 1ps
`default_nettype none
module dnyd_date (
    input  wire logic                            i_clk,
    input  wire logic [dnyd_pkg::NUM_STAGES-1:0] i_adv,
    input  wire logic [dnyd_pkg::W_DAY-1:0]      i_mjd_day,
    output logic      [dnyd_pkg::W_YEAR-1:0]     o_year,
    output logic      [dnyd_pkg::W_DOY-1:0]      o_day_of_year
);

    localparam int W_P1 = dnyd_pkg::W_X1 + dnyd_pkg::W_R1;
    localparam int W_P2 = dnyd_pkg::W_X2 + dnyd_pkg::W_R2;
    localparam int W_P3 = dnyd_pkg::W_X3 + dnyd_pkg::W_R3;
    localparam int W_T2 = 25;
    localparam int W_T5 = 18;
    localparam int W_S5 = 17;
    localparam int W_R  = dnyd_pkg::W_I + 1;

    logic [dnyd_pkg::W_L0-1:0]   r_s0_l0;
    logic [dnyd_pkg::W_L0-1:0]   r_s1_l0;
    logic [dnyd_pkg::W_N-1:0]    r_s1_n;
    logic [dnyd_pkg::W_L1-1:0]   r_s2_l1;
    logic [dnyd_pkg::W_N-1:0]    r_s2_n;
    logic [dnyd_pkg::W_X2-1:0]   r_s3_x2;
    logic [dnyd_pkg::W_L1-1:0]   r_s3_l1;
    logic [dnyd_pkg::W_N-1:0]    r_s3_n;
    logic [dnyd_pkg::W_I-1:0]    r_s4_i;
    logic [dnyd_pkg::W_L1-1:0]   r_s4_l1;
    logic [dnyd_pkg::W_N-1:0]    r_s4_n;
    logic [dnyd_pkg::W_L2-1:0]   r_s5_l2;
    logic [dnyd_pkg::W_I-1:0]    r_s5_i;
    logic [dnyd_pkg::W_N-1:0]    r_s5_n;
    logic [dnyd_pkg::W_X3-1:0]   r_s6_x3;
    logic [dnyd_pkg::W_L2-1:0]   r_s6_l2;
    logic [dnyd_pkg::W_I-1:0]    r_s6_i;
    logic [dnyd_pkg::W_N-1:0]    r_s6_n;
    logic [dnyd_pkg::W_J-1:0]    r_s7_j;
    logic [dnyd_pkg::W_L2-1:0]   r_s7_l2;
    logic [dnyd_pkg::W_I-1:0]    r_s7_i;
    logic [dnyd_pkg::W_N-1:0]    r_s7_n;
    logic [dnyd_pkg::W_YEAR-1:0] r_s8_year;
    logic [dnyd_pkg::W_M-1:0]    r_s8_m;
    logic [dnyd_pkg::W_DOY-1:0]  r_s8_d;
    logic [W_R-1:0]              r_s8_r;
    logic [1:0]                  r_s8_c2;
    logic [dnyd_pkg::W_YEAR-1:0] r_s9_year;
    logic [dnyd_pkg::W_DOY-1:0]  r_s9_doy;

    logic [dnyd_pkg::W_L0-1:0]   n_s0_l0;
    logic [W_P1-1:0]             n_p1;
    logic [W_T2-1:0]             n_t2;
    logic [dnyd_pkg::W_L0-1:0]   n_l1_full;
    logic [dnyd_pkg::W_X2-1:0]   n_x2;
    logic [W_P2-1:0]             n_p2;
    logic [W_T5-1:0]             n_t5;
    logic [W_S5-1:0]             n_l2_full;
    logic [dnyd_pkg::W_X3-1:0]   n_x3;
    logic [W_P3-1:0]             n_p3;
    logic                        n_lf;
    logic [dnyd_pkg::W_M-1:0]    n_m;
    logic [dnyd_pkg::W_L2-1:0]   n_d;
    logic [W_R-1:0]              n_r;
    logic [dnyd_pkg::W_N-1:0]    n_c;
    logic [dnyd_pkg::W_YEAR-1:0] n_year;
    logic                        n_leap;
    logic [dnyd_pkg::W_DOY-1:0]  n_doy;

    always_comb begin
        n_s0_l0   = dnyd_pkg::W_L0'(i_mjd_day) + dnyd_pkg::W_L0'(dnyd_pkg::L_OFFSET);
        n_p1      = W_P1'({r_s0_l0, 2'b00}) * W_P1'(dnyd_pkg::R1);
        n_t2      = W_T2'(dnyd_pkg::DAYS_400Y) * W_T2'(r_s1_n) + W_T2'(3);
        n_l1_full = r_s1_l0 - dnyd_pkg::W_L0'(n_t2[W_T2-1:2]);
        n_x2      = (dnyd_pkg::W_X2'(r_s2_l1) + dnyd_pkg::W_X2'(1))
                    * dnyd_pkg::W_X2'(4000);
        n_p2      = W_P2'(r_s3_x2) * W_P2'(dnyd_pkg::R2);
        n_t5      = W_T5'(1461) * W_T5'(r_s4_i);
        n_l2_full = W_S5'(r_s4_l1) - W_S5'(n_t5[W_T5-1:2]) + W_S5'(31);
        n_x3      = dnyd_pkg::W_X3'(r_s5_l2) * dnyd_pkg::W_X3'(80);
        n_p3      = W_P3'(r_s6_x3) * W_P3'(dnyd_pkg::R3);

        n_lf   = (r_s7_j >= dnyd_pkg::W_J'(11));
        n_m    = r_s7_j + dnyd_pkg::W_M'(2) - (n_lf ? dnyd_pkg::W_M'(12) : dnyd_pkg::W_M'(0));
        n_d    = r_s7_l2 - dnyd_pkg::W_L2'(dnyd_pkg::f_month_off(r_s7_j));
        n_r    = W_R'(r_s7_i) + W_R'(n_lf);
        n_c    = r_s7_n - dnyd_pkg::W_N'(dnyd_pkg::FVF_CENT);
        n_year = dnyd_pkg::W_YEAR'(7'd100) * dnyd_pkg::W_YEAR'(n_c)
                 + dnyd_pkg::W_YEAR'(n_r);

        // year = 100*c + r; leap test without a modulo on the full year
        if (r_s8_r == W_R'(0)) begin
            n_leap = (r_s8_c2 == 2'd0);
        end else if (r_s8_r == W_R'(100)) begin
            n_leap = (r_s8_c2 == 2'd3);
        end else begin
            n_leap = (r_s8_r[1:0] == 2'd0);
        end
        n_doy = dnyd_pkg::f_month_start(r_s8_m - dnyd_pkg::W_M'(1)) + r_s8_d
                + dnyd_pkg::W_DOY'((r_s8_m > dnyd_pkg::W_M'(2)) && n_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_s0_l0 <= n_s0_l0;
        end
        if (i_adv[1]) begin
            r_s1_l0 <= r_s0_l0;
            r_s1_n  <= n_p1[dnyd_pkg::K1 +: dnyd_pkg::W_N];
        end
        if (i_adv[2]) begin
            r_s2_l1 <= n_l1_full[dnyd_pkg::W_L1-1:0];
            r_s2_n  <= r_s1_n;
        end
        if (i_adv[3]) begin
            r_s3_x2 <= n_x2;
            r_s3_l1 <= r_s2_l1;
            r_s3_n  <= r_s2_n;
        end
        if (i_adv[4]) begin
            r_s4_i  <= n_p2[dnyd_pkg::K2 +: dnyd_pkg::W_I];
            r_s4_l1 <= r_s3_l1;
            r_s4_n  <= r_s3_n;
        end
        if (i_adv[5]) begin
            r_s5_l2 <= n_l2_full[dnyd_pkg::W_L2-1:0];
            r_s5_i  <= r_s4_i;
            r_s5_n  <= r_s4_n;
        end
        if (i_adv[6]) begin
            r_s6_x3 <= n_x3;
            r_s6_l2 <= r_s5_l2;
            r_s6_i  <= r_s5_i;
            r_s6_n  <= r_s5_n;
        end
        if (i_adv[7]) begin
            r_s7_j  <= n_p3[dnyd_pkg::K3 +: dnyd_pkg::W_J];
            r_s7_l2 <= r_s6_l2;
            r_s7_i  <= r_s6_i;
            r_s7_n  <= r_s6_n;
        end
        if (i_adv[8]) begin
            r_s8_year <= n_year;
            r_s8_m    <= n_m;
            r_s8_d    <= n_d[dnyd_pkg::W_DOY-1:0];
            r_s8_r    <= n_r;
            r_s8_c2   <= n_c[1:0];
        end
        if (i_adv[9]) begin
            r_s9_year <= r_s8_year;
            r_s9_doy  <= n_doy;
        end
    end

    assign o_year        = r_s9_year;
    assign o_day_of_year = r_s9_doy;

endmodule
`default_nettype wire

FILE: hw/rtl/day_number_to_year_and_day_core.sv
// Top level: MJD and day fraction to Gregorian year, day of year and seconds of day.
// Throughput: one word per cycle while the output is not stalled; each stage holds one word with its own valid bit.
// Stalls ripple back stage by stage, so empty stages still accept while the output waits.
// Reset clears the stage valid bits only; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module day_number_to_year_and_day_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [dnyd_pkg::W_DAY-1:0]    i_mjd_day,
    input  wire logic [dnyd_pkg::W_FRAC-1:0]   i_day_fraction,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [dnyd_pkg::W_YEAR-1:0]   o_year,
    output logic      [dnyd_pkg::W_DOY-1:0]    o_day_of_year,
    output logic      [dnyd_pkg::W_SEC-1:0]    o_seconds_of_day
);

    localparam int NS = dnyd_pkg::NUM_STAGES;

    logic [NS-1:0]                    r_vld;
    logic [NS-1:0]                    n_adv;
    logic [dnyd_pkg::W_SEC_PROD-1:0]  n_sec_prod;
    logic [dnyd_pkg::W_SEC-1:0]       r_sec [NS];

    always_comb begin
        n_adv[NS-1] = ~r_vld[NS-1] | i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            n_adv[k] = ~r_vld[k] | n_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign n_sec_prod = dnyd_pkg::W_SEC_PROD'(i_day_fraction)
                        * dnyd_pkg::W_SEC_PROD'(dnyd_pkg::SEC_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_sec[0] <= n_sec_prod[dnyd_pkg::SEC_FRAC_BITS +: dnyd_pkg::W_SEC];
        end
        for (int k = 1; k < NS; k++) begin
            if (n_adv[k]) begin
                r_sec[k] <= r_sec[k-1];
            end
        end
    end

    dnyd_date u_date (
        .i_clk         (i_clk),
        .i_adv         (n_adv),
        .i_mjd_day     (i_mjd_day),
        .o_year        (o_year),
        .o_day_of_year (o_day_of_year)
    );

    assign o_ready          = n_adv[0];
    assign o_valid          = r_vld[NS-1];
    assign o_seconds_of_day = r_sec[NS-1];

    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day_of_year >= 9'd1) && (o_day_of_year <= 9'd366))
        else $error("day of year out of range");

    a_year_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year >= 14'd1858))
        else $error("year below first representable year");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled with a free stage");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted word not captured");

endmodule
`default_nettype wire
